@@ rtl/sds_pkg.sv @@
package sds_pkg;

   localparam int ValW = 7;
   localparam int IdxW = 6;

   // Result of the greedy walk, passed from the walker to the output stage.
   typedef struct packed {
      logic [ValW-1:0] value;
      logic            last;
      logic            status;
   } result_type;

   // Walker state machine, one-hot encoded.
   typedef enum logic [7:0] {
      W_IDLE  = 8'b00000001,
      W_CHECK = 8'b00000010,
      W_READ  = 8'b00000100,
      W_STEP  = 8'b00001000,
      W_POP   = 8'b00010000,
      W_PREP  = 8'b00100000,
      W_EMIT  = 8'b01000000,
      W_ERR   = 8'b10000000
   } walk_state_type;

endpackage

@@ rtl/smallest_distinct_subsequence_top.sv @@
// Smallest subsequence of distinct values. Items arrive one per cycle while
// loading; each in-range item, while the memory has room, is written into a
// sequence memory, and the last position and seen flag of its value are
// updated; any other item marks the run invalid. The item marked last hands
// the run to the walker through a register. The walker checks the run, then
// reads the stored sequence back element by element (memory read, then one
// stack step), with each stack pop adding the pop step and a read of the new
// stack top. A valid run then fetches the bottom of the stack and emits K
// results, one per cycle; an invalid run emits a single error result with
// status 1. busy stays high from the last item until the final result has
// been shown. The receiver cannot stall: each result is valid for exactly
// one cycle when rsp_valid is high. The value_count register is written
// through the csr_ channel whenever csr_valid is high; csr_ready is always
// high.
module smallest_distinct_subsequence_top #(
   parameter int MaxLen    = 4096,
   parameter int MaxValues = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [6:0] req_value,
   input  logic       req_last,
   output logic       rsp_valid,
   output logic [6:0] rsp_value_res,
   output logic       rsp_last_res,
   output logic       rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data
);

   localparam int AddrW = $clog2(MaxLen);
   localparam int LenW  = $clog2(MaxLen + 1);

   logic [6:0]           value_count_ff;
   logic [LenW-1:0]      len_ff;
   logic                 err_ff;
   logic [MaxValues-1:0] seen_ff;
   logic                 busy_ff;
   logic                 accept;
   logic                 in_range;
   logic                 store;
   logic [5:0]           elem;
   logic                 go;
   logic                 go_ff;
   logic                 done;
   logic [AddrW-1:0]     rd_addr;
   logic [5:0]           rd_data;
   logic [5:0]           lp_addr;
   logic [AddrW-1:0]     lp_data;
   logic                 res_valid;
   sds_pkg::result_type  res;
   logic [LenW-1:0]      len_now;
   logic                 err_now;
   logic [MaxValues-1:0] seen_now;
   logic [LenW-1:0]      len_hold_ff;
   logic                 err_hold_ff;
   logic [MaxValues-1:0] seen_hold_ff;
   logic [AddrW-1:0]     walk_addr;

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;
   assign accept    = start && !busy_ff;
   assign in_range  = (req_value != 7'd0) && (req_value <= 7'(MaxValues));
   assign store     = accept && in_range && (len_ff < LenW'(MaxLen));
   assign elem      = 6'(req_value - 7'd1);
   assign go        = accept && req_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_count_ff <= 7'd64;
         len_ff  <= '0;
         err_ff  <= 1'b0;
         seen_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         if (csr_valid) value_count_ff <= csr_data;
         if (done) begin
            len_ff  <= '0;
            err_ff  <= 1'b0;
            seen_ff <= '0;
            busy_ff <= 1'b0;
         end else begin
            if (go) busy_ff <= 1'b1;
            if (accept && !store) err_ff <= 1'b1;
            if (store) begin
               len_ff <= len_ff + LenW'(1);
               seen_ff[elem] <= 1'b1;
            end
         end
      end
   end

   // The error flag and length include the last item itself.
   assign len_now  = store ? len_ff + LenW'(1) : len_ff;
   assign err_now  = err_ff || (accept && !store);
   always_comb begin
      seen_now = seen_ff;
      if (store) seen_now[elem] = 1'b1;
   end
   always_ff @(posedge clock) begin
      if (go) begin
         len_hold_ff  <= len_now;
         err_hold_ff  <= err_now;
         seen_hold_ff <= seen_now;
      end
   end

   sds_ram #(.Width(6), .Depth(MaxLen)) u_seq (
      .clock  (clock),
      .wr_en  (store),
      .wr_addr(len_ff[AddrW-1:0]),
      .wr_data(elem),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Last position of each value, looked up by the walker at the stack top.
   sds_ram #(.Width(AddrW), .Depth(MaxValues)) u_last_pos (
      .clock  (clock),
      .wr_en  (store),
      .wr_addr(elem),
      .wr_data(len_ff[AddrW-1:0]),
      .rd_addr(lp_addr),
      .rd_data(lp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) go_ff <= 1'b0;
      else       go_ff <= go;
   end

   // Walker reads pos-1: feed it the address minus one.
   assign rd_addr = walk_addr - AddrW'(1);

   sds_walk #(.MaxValues(MaxValues), .LenW(LenW), .AddrW(AddrW)) u_walk (
      .clock      (clock),
      .reset      (reset),
      .go         (go_ff),
      .length     (len_hold_ff),
      .error_in   (err_hold_ff),
      .seen       (seen_hold_ff),
      .value_count(value_count_ff),
      .rd_addr    (walk_addr),
      .rd_data    (rd_data),
      .lp_addr    (lp_addr),
      .lp_data    (lp_data),
      .done       (done),
      .res_valid  (res_valid),
      .res        (res)
   );

   assign rsp_valid     = res_valid;
   assign rsp_value_res = res.value;
   assign rsp_last_res  = res.last;
   assign rsp_status    = res.status;

endmodule

@@ rtl/sds_ram.sv @@
module sds_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sds_walk.sv @@
// Back end: checks the loaded run and walks it with a stack greedy,
// then drains the stack bottom to top as results, or emits a single error result for an invalid run.
module sds_walk #(
   parameter int MaxValues = 64,
   parameter int LenW      = 13,
   parameter int AddrW     = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [LenW-1:0]           length,
   input  logic                      error_in,
   input  logic [MaxValues-1:0]      seen,
   input  logic [sds_pkg::ValW-1:0]  value_count,
   output logic [AddrW-1:0]          rd_addr,
   input  logic [sds_pkg::IdxW-1:0]  rd_data,
   output logic [sds_pkg::IdxW-1:0]  lp_addr,
   input  logic [AddrW-1:0]          lp_data,
   output logic                      done,
   output logic                      res_valid,
   output sds_pkg::result_type       res
);

   localparam int SpW  = $clog2(MaxValues + 1);
   localparam int StkW = $clog2(MaxValues);

   sds_pkg::walk_state_type state_ff, state_in;
   logic [LenW-1:0]          pos_ff, pos_in;
   logic [SpW-1:0]           sp_ff, sp_in;
   logic [SpW-1:0]           out_ff, out_in;
   logic [MaxValues-1:0]     taken_ff, taken_in;
   logic [sds_pkg::IdxW-1:0] top_ff, top_in;
   logic                     push;
   logic                     pop;
   logic                     bad_val;
   logic                     missing;
   logic [MaxValues-1:0]     need;
   logic [SpW-1:0]           sp_dec2;
   logic [SpW-1:0]           out_inc;
   logic [StkW-1:0]          stk_rd_addr;
   logic [sds_pkg::IdxW-1:0] stk_rd_data;

   assign rd_addr = pos_ff[AddrW-1:0];
   assign sp_dec2 = sp_ff - SpW'(2);
   assign out_inc = out_ff + SpW'(1);

   // The last position of the stack top is looked up by a registered read ahead of the step; after a
   // pop the new top comes straight from the stack memory.
   assign lp_addr = (state_ff == sds_pkg::W_POP) ? stk_rd_data : top_ff;

   always_comb begin
      for (int i = 0; i < MaxValues; i++) begin
         need[i] = (i < int'(value_count));
      end
   end
   assign missing = |(need & ~seen);
   // A seen value above K means some stored value is out of range.
   assign bad_val = |(seen & ~need);

   assign pop = (sp_ff != '0) && (top_ff > rd_data) &&
                ({1'b0, lp_data} > pos_ff - LenW'(1));

   sds_ram #(.Width(sds_pkg::IdxW), .Depth(MaxValues)) u_stack (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(sp_ff[StkW-1:0]),
      .wr_data(rd_data),
      .rd_addr(stk_rd_addr),
      .rd_data(stk_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      sp_in       = sp_ff;
      out_in      = out_ff;
      taken_in    = taken_ff;
      top_in      = top_ff;
      push        = 1'b0;
      done        = 1'b0;
      res_valid   = 1'b0;
      res         = '0;
      stk_rd_addr = '0;
      unique case (state_ff)
         sds_pkg::W_IDLE: begin
            if (go) begin
               state_in = sds_pkg::W_CHECK;
            end
         end
         sds_pkg::W_CHECK: begin
            taken_in = '0;
            sp_in    = '0;
            out_in   = '0;
            pos_in   = '0;
            if (error_in || value_count == '0 ||
                value_count > sds_pkg::ValW'(MaxValues) || missing || bad_val) begin
               state_in = sds_pkg::W_ERR;
            end else begin
               state_in = sds_pkg::W_READ;
               pos_in   = LenW'(1);
            end
         end
         sds_pkg::W_READ: begin
            // The element at pos-1 and the last position of the top are read now.
            state_in = sds_pkg::W_STEP;
         end
         sds_pkg::W_STEP: begin
            if (taken_ff[rd_data]) begin
               if (pos_ff == length) state_in = sds_pkg::W_PREP;
               else begin
                  pos_in   = pos_ff + LenW'(1);
                  state_in = sds_pkg::W_READ;
               end
            end else if (pop) begin
               taken_in[top_ff] = 1'b0;
               sp_in       = sp_ff - SpW'(1);
               stk_rd_addr = sp_dec2[StkW-1:0];
               state_in    = sds_pkg::W_POP;
            end else begin
               if (sp_ff < SpW'(MaxValues)) begin
                  push = 1'b1;
                  taken_in[rd_data] = 1'b1;
                  sp_in  = sp_ff + SpW'(1);
                  top_in = rd_data;
               end
               if (pos_ff == length) state_in = sds_pkg::W_PREP;
               else begin
                  pos_in   = pos_ff + LenW'(1);
                  state_in = sds_pkg::W_READ;
               end
            end
         end
         sds_pkg::W_POP: begin
            top_in   = stk_rd_data;
            state_in = sds_pkg::W_STEP;
         end
         sds_pkg::W_PREP: begin
            // The bottom entry is read here so that results follow every cycle.
            state_in = sds_pkg::W_EMIT;
         end
         sds_pkg::W_EMIT: begin
            res_valid   = 1'b1;
            res.value   = sds_pkg::ValW'(stk_rd_data) + sds_pkg::ValW'(1);
            res.last    = (out_inc == sp_ff);
            stk_rd_addr = out_inc[StkW-1:0];
            out_in      = out_inc;
            if (res.last) begin
               state_in = sds_pkg::W_IDLE;
               done     = 1'b1;
            end
         end
         sds_pkg::W_ERR: begin
            res_valid  = 1'b1;
            res.last   = 1'b1;
            res.status = 1'b1;
            state_in   = sds_pkg::W_IDLE;
            done       = 1'b1;
         end
         default: state_in = sds_pkg::W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sds_pkg::W_IDLE;
         sp_ff    <= '0;
         taken_ff <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         taken_ff <= taken_in;
      end
      pos_ff <= pos_in;
      out_ff <= out_in;
      top_ff <= top_in;
   end

endmodule

@@ rtl/sds_check.sv @@
module sds_check (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_last_res,
   input logic rsp_status
);

   // A result only appears while the block is busy.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");

   // An error result is always the final one.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last_res) else $error("error not last");

   // The final result frees the block.
   a_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_res |=> !busy) else $error("busy after last");

   // A transfer of the last item makes the block busy.
   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last |=> busy) else $error("not busy after last item");

endmodule

bind smallest_distinct_subsequence_top sds_check u_check (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_last    (req_last),
   .rsp_valid   (rsp_valid),
   .rsp_last_res(rsp_last_res),
   .rsp_status  (rsp_status)
);
